@@ design/pfe_pkg.sv @@
`timescale 1ns / 1ps

package pfe_pkg;

	// Framing bytes and limits
	localparam logic [7:0]  STX_BYTE        = 8'h02;
	localparam logic [7:0]  ETX_BYTE        = 8'h03;
	localparam logic [7:0]  CK_BIAS         = 8'h80;
	localparam int unsigned MAX_FRAME_BYTES = 8192;

	// Descriptor queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Configuration register indexes
	localparam logic [1:0] REG_STX_ETX   = 2'd0;
	localparam logic [1:0] REG_SIZE      = 2'd1;
	localparam logic [1:0] REG_CK_MODE   = 2'd2;
	localparam logic [1:0] REG_HEX       = 2'd3;

	// Checksum modes
	typedef enum logic [1:0] {
		CK_NONE  = 2'd0,
		CK_ZERO  = 2'd1,
		CK_SUM80 = 2'd2,
		CK_NEG   = 2'd3
	} ck_mode_t;

	// Output byte slots of one transaction, in wire order
	localparam int unsigned NUM_SLOTS = 8;
	localparam logic [2:0] SLOT_STX   = 3'd0;
	localparam logic [2:0] SLOT_LENLO = 3'd1;
	localparam logic [2:0] SLOT_LENHI = 3'd2;
	localparam logic [2:0] SLOT_DHI   = 3'd3;
	localparam logic [2:0] SLOT_DLO   = 3'd4;
	localparam logic [2:0] SLOT_CKHI  = 3'd5;
	localparam logic [2:0] SLOT_CKLO  = 3'd6;
	localparam logic [2:0] SLOT_ETX   = 3'd7;

	// One classified transaction
	typedef struct packed {
		logic [7:0]           data;
		logic [15:0]          len;
		logic [7:0]           ck;
		logic                 hex;
		logic                 last;
		logic [NUM_SLOTS-1:0] slots;
	} desc_t;

	// Uppercase ASCII hex digit of a nibble
	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return 8'h30 + {4'd0, nib};
		end else begin
			return 8'h37 + {4'd0, nib};
		end
	endfunction

endpackage

@@ design/pfe_front.sv @@
`timescale 1ns / 1ps

module pfe_front import pfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        accept,
	input  logic [7:0]  payload_byte,
	input  logic [13:0] frame_length,
	input  logic        first_of_frame,
	input  logic        last_of_frame,
	output desc_t       desc
);

	logic     stx_en_q;
	logic     size_en_q;
	ck_mode_t ck_mode_q;
	logic     hex_q;
	logic [7:0] sum_q;

	logic [7:0]  sum_new;
	logic [15:0] len_sat;
	logic        ck_on;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stx_en_q  <= 1'b0;
			size_en_q <= 1'b1;
			ck_mode_q <= CK_SUM80;
			hex_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STX_ETX: stx_en_q  <= cfg_data[0];
				REG_SIZE:    size_en_q <= cfg_data[0];
				REG_CK_MODE: ck_mode_q <= ck_mode_t'(cfg_data);
				REG_HEX:     hex_q     <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	// Running sum restarts on the first byte of a frame
	assign sum_new = (first_of_frame ? 8'd0 : sum_q) + payload_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= 8'd0;
		end else if (accept) begin
			sum_q <= sum_new;
		end
	end

	// Length field saturates at the frame limit
	assign len_sat = ({2'b00, frame_length} > 16'(MAX_FRAME_BYTES)) ?
		16'(MAX_FRAME_BYTES) : {2'b00, frame_length};

	assign ck_on = (ck_mode_q != CK_NONE);

	// Classify the transaction into the byte slots it produces
	always_comb begin
		desc.data = payload_byte;
		desc.len  = len_sat;
		desc.hex  = hex_q;
		desc.last = last_of_frame;
		case (ck_mode_q)
			CK_SUM80: desc.ck = CK_BIAS + sum_new;
			CK_NEG:   desc.ck = 8'd0 - sum_new;
			default:  desc.ck = 8'd0;
		endcase
		desc.slots             = '0;
		desc.slots[SLOT_STX]   = first_of_frame & stx_en_q;
		desc.slots[SLOT_LENLO] = first_of_frame & size_en_q;
		desc.slots[SLOT_LENHI] = first_of_frame & size_en_q;
		desc.slots[SLOT_DHI]   = hex_q;
		desc.slots[SLOT_DLO]   = 1'b1;
		desc.slots[SLOT_CKHI]  = last_of_frame & ck_on & hex_q;
		desc.slots[SLOT_CKLO]  = last_of_frame & ck_on;
		desc.slots[SLOT_ETX]   = last_of_frame & stx_en_q;
	end

endmodule

@@ design/pfe_queue.sv @@
`timescale 1ns / 1ps

module pfe_queue import pfe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output desc_t head
);

	desc_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

@@ design/pfe_back.sv @@
`timescale 1ns / 1ps

module pfe_back import pfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	input  desc_t      head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       frame_end
);

	logic [NUM_SLOTS-1:0] sent_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 run_end_q;
	logic                 frame_end_q;

	logic [NUM_SLOTS-1:0] rem;
	logic [NUM_SLOTS-1:0] sel;
	logic [2:0]           sel_idx;
	logic [7:0]           byte_nxt;
	logic                 last_slot;
	logic                 load;

	// Slots still to send for the head transaction, lowest first
	assign rem = head.slots & ~sent_q;

	always_comb begin
		sel_idx = SLOT_ETX;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (rem[i]) begin
				sel_idx = 3'(i);
			end
		end
	end

	assign sel       = rem & (~rem + 1'b1);
	assign last_slot = ((rem & ~sel) == '0);
	assign load      = !empty && (!out_valid_q || out_ready);
	assign pop       = load && last_slot;

	// Byte for the chosen slot
	always_comb begin
		case (sel_idx)
			SLOT_STX:   byte_nxt = STX_BYTE;
			SLOT_LENLO: byte_nxt = head.len[7:0];
			SLOT_LENHI: byte_nxt = head.len[15:8];
			SLOT_DHI:   byte_nxt = hex_digit(head.data[7:4]);
			SLOT_DLO:   byte_nxt = head.hex ? hex_digit(head.data[3:0]) : head.data;
			SLOT_CKHI:  byte_nxt = hex_digit(head.ck[7:4]);
			SLOT_CKLO:  byte_nxt = head.hex ? hex_digit(head.ck[3:0]) : head.ck;
			SLOT_ETX:   byte_nxt = ETX_BYTE;
			default:    byte_nxt = ETX_BYTE;
		endcase
	end

	// Progress through the head transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q <= '0;
		end else if (load) begin
			sent_q <= last_slot ? '0 : (sent_q | sel);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= byte_nxt;
			run_end_q   <= last_slot;
			frame_end_q <= last_slot & head.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_end   = run_end_q;
	assign frame_end = frame_end_q;

endmodule

@@ design/packet_frame_encoder.sv @@
`timescale 1ns / 1ps
// Packet frame encoder: turns payload bytes into a framed wire byte stream.
// Input channel (in_valid/in_ready) takes one payload byte per transaction,
// with its frame marks and the frame length (read on the first byte).
// Output channel (out_valid/out_ready) gives one wire byte per transaction;
// run_end marks the last byte caused by an input, frame_end the last byte
// of a frame. Registers are written through cfg_we/cfg_index/cfg_data and
// take effect on the next input; write them only while the block is idle.
// The input's descriptor is written into the queue, then the back end loads
// its first wire byte into the output register. Each input yields 1 to 8
// wire bytes, one byte per cycle while out_ready is high: two bytes per
// payload byte in hex mode, one in raw, plus header/trailer at frame edges.
// The output byte rate sets throughput. A 4-entry descriptor queue lets
// inputs keep arriving while the output drains or is stalled; in_ready
// drops only when that queue is full. When the receiver stalls, the output
// byte holds. Reset empties the queue, clears the running checksum and
// loads the register defaults (no STX/ETX, length on, sum+0x80, raw).

module packet_frame_encoder import pfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  payload_byte,
	input  logic [13:0] frame_length,
	input  logic        first_of_frame,
	input  logic        last_of_frame,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        run_end,
	output logic        frame_end
);

	desc_t front_desc;
	desc_t head_desc;
	logic  accept;
	logic  q_full;
	logic  q_empty;
	logic  q_pop;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Classification and checksum
	pfe_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.accept         (accept),
		.payload_byte   (payload_byte),
		.frame_length   (frame_length),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.desc           (front_desc)
	);

	// Descriptor queue
	pfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_desc (front_desc),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (head_desc)
	);

	// Byte sequencer and output register
	pfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (head_desc),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_end   (run_end),
		.frame_end (frame_end)
	);

endmodule
